FILE: design/gic_pkg.sv
// Shared types and constants of the gamepad input conditioner.
package gic_pkg;

	localparam int unsigned DZ_W = 15;
	localparam int unsigned BTN_W = 16;
	localparam int unsigned AXIS_W = 16;
	localparam int unsigned STEPS_W = 6;

	localparam logic REG_LEFT_DZ = 1'b0;
	localparam logic REG_RIGHT_DZ = 1'b1;

	localparam logic [DZ_W-1:0] LEFT_DZ_RESET = 15'd7849;
	localparam logic [DZ_W-1:0] RIGHT_DZ_RESET = 15'd8689;
	localparam logic [DZ_W-1:0] DZ_FULL = 15'd32767;
	localparam logic [31:0] FULL_RANGE_SQ = 32'd1073676289;
	localparam logic [15:0] SPEED_MAX = 16'hFFFF;
	localparam logic [15:0] DIR_MAX = 16'h7FFF;

	localparam logic [STEPS_W-1:0] UNIT_DIV_STEPS = 6'd31;
	localparam logic [STEPS_W-1:0] UNIT_SQRT_STEPS = 6'd16;
	localparam logic [STEPS_W-1:0] SPEED_SQRT_STEPS = 6'd32;
	localparam logic [STEPS_W-1:0] SPEED_DIV_STEPS = 6'd16;
	localparam logic [63:0] UNIT_SQRT_BIT = 64'h0000_0000_4000_0000;
	localparam logic [63:0] SPEED_SQRT_BIT = 64'h4000_0000_0000_0000;

	typedef struct packed {
		logic [BTN_W-1:0] buttons;
		logic signed [AXIS_W-1:0] left_x;
		logic signed [AXIS_W-1:0] left_y;
		logic signed [AXIS_W-1:0] right_x;
		logic signed [AXIS_W-1:0] right_y;
	} prev_t;

	typedef enum logic [1:0] {
		OP_DIV = 2'b01,
		OP_SQRT = 2'b10
	} math_op_t;

	typedef struct packed {
		logic start;
		math_op_t op;
		logic [63:0] a;
		logic [63:0] b;
		logic [STEPS_W-1:0] steps;
	} math_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] value;
	} math_rsp_t;

endpackage

FILE: design/gic_in_if.sv
// Report channel carrying one pad report per transfer.
interface gic_in_if;
	logic valid;
	logic ready;
	logic [1:0] pad_index;
	logic [15:0] buttons;
	logic signed [15:0] left_x;
	logic signed [15:0] left_y;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;

	modport source (output valid, pad_index, buttons, left_x, left_y, right_x, right_y,
		input ready);
	modport sink (input valid, pad_index, buttons, left_x, left_y, right_x, right_y,
		output ready);
endinterface

FILE: design/gic_out_if.sv
// Result channel carrying one conditioned report per transfer.
interface gic_out_if;
	logic valid;
	logic ready;
	logic [15:0] pressed_edges;
	logic [15:0] released_edges;
	logic signed [15:0] direction_x;
	logic signed [15:0] direction_y;
	logic [15:0] speed;
	logic left_changed;
	logic right_changed;

	modport source (output valid, pressed_edges, released_edges, direction_x, direction_y,
		speed, left_changed, right_changed, input ready);
	modport sink (input valid, pressed_edges, released_edges, direction_x, direction_y,
		speed, left_changed, right_changed, output ready);
endinterface

FILE: design/gamepad_input_conditioner_top.sv
// Top level of the gamepad input conditioner.
//
// Reports enter on in_ch and one conditioned result per report leaves on
// out_ch; a transfer happens at a clock edge where valid and ready are high.
// The previous report of each pad lives in a small RAM and is read, compared
// and overwritten for every report.
// Dead zone registers are written through cfg_we, cfg_index and cfg_data.
// A report inside the left dead zone needs no arithmetic. Outside it, the
// shared unit, which does one divide or square-root step per cycle, runs
// two 31-step divides and two 16-step roots for the direction, then, unless
// the speed saturates, a 32-step root and a 16-step divide for the speed.
// One report is worked on at a time; in_ch.ready is high only when idle.
// A finished result waits in an output register, so the next report is
// accepted while out_ch is stalled; the block then waits before delivering.
// Reset sets the control and dead zone registers to their defaults and
// marks every pad as having an all-zero previous report.
module gamepad_input_conditioner_top #(
	parameter int PAD_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [gic_pkg::DZ_W-1:0] cfg_data,
	gic_in_if.sink in_ch,
	gic_out_if.source out_ch
);
	import gic_pkg::*;

	localparam int PAD_AW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_READ = 12'b0000_0000_0010,
		ST_MULY = 12'b0000_0000_0100,
		ST_SUM = 12'b0000_0000_1000,
		ST_CHECK = 12'b0000_0001_0000,
		ST_DIVX = 12'b0000_0010_0000,
		ST_SQX = 12'b0000_0100_0000,
		ST_DIVY = 12'b0000_1000_0000,
		ST_SQY = 12'b0001_0000_0000,
		ST_SPD = 12'b0010_0000_0000,
		ST_SPDDIV = 12'b0100_0000_0000,
		ST_DONE = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	logic [DZ_W-1:0] left_dz_q;
	logic [DZ_W-1:0] right_dz_q;
	logic [PAD_COUNT-1:0] valid_q;

	logic [PAD_AW-1:0] pad_q;
	prev_t cur_q;
	logic [31:0] sqx_q;
	logic [31:0] sqy_q;
	logic [29:0] dz2_q;
	logic [31:0] s_q;

	logic [15:0] pressed_q;
	logic [15:0] released_q;
	logic signed [15:0] dir_x_q;
	logic signed [15:0] dir_y_q;
	logic [15:0] speed_q;
	logic lchg_q;
	logic rchg_q;

	logic out_valid_q;
	logic [15:0] out_pressed_q;
	logic [15:0] out_released_q;
	logic signed [15:0] out_dir_x_q;
	logic signed [15:0] out_dir_y_q;
	logic [15:0] out_speed_q;
	logic out_lchg_q;
	logic out_rchg_q;

	math_req_t math_req_q;
	math_rsp_t math_rsp;

	logic accept;
	logic pad_ok;
	logic [$bits(prev_t)-1:0] ram_rdata;
	prev_t prev;
	logic [15:0] ax;
	logic [15:0] ay;
	logic [31:0] spd_num;
	logic [DZ_W-1:0] spd_den;

	function automatic logic [15:0] mag(logic signed [15:0] v);
		logic [15:0] n;
		n = v;
		return v[15] ? (~n + 16'd1) : n;
	endfunction

	function automatic logic in_square(logic signed [15:0] x, logic signed [15:0] y,
		logic [DZ_W-1:0] dz);
		return (mag(x) <= {1'b0, dz}) && (mag(y) <= {1'b0, dz});
	endfunction

	function automatic logic stick_changed(logic signed [15:0] cx, logic signed [15:0] cy,
		logic signed [15:0] px, logic signed [15:0] py, logic [DZ_W-1:0] dz);
		logic ci;
		logic pi;
		ci = in_square(cx, cy, dz);
		pi = in_square(px, py, dz);
		return (ci != pi) || (!ci && ((cx != px) || (cy != py)));
	endfunction

	function automatic logic signed [15:0] to_dir(logic [31:0] root, logic neg);
		logic [15:0] m;
		m = (root > 32'(DIR_MAX)) ? DIR_MAX : root[15:0];
		return neg ? (~m + 16'd1) : m;
	endfunction

	assign accept = in_ch.valid && in_ch.ready;
	assign pad_ok = 32'(in_ch.pad_index) < PAD_COUNT;
	assign in_ch.ready = (state_q == ST_IDLE);

	assign prev = valid_q[pad_q] ? prev_t'(ram_rdata) : prev_t'('0);
	assign ax = mag(cur_q.left_x);
	assign ay = mag(cur_q.left_y);
	assign spd_num = math_rsp.value - {1'b0, left_dz_q, 16'b0};
	assign spd_den = DZ_FULL - left_dz_q;

	gic_ram #(
		.WIDTH($bits(prev_t)),
		.DEPTH(PAD_COUNT)
	) u_ram (
		.clk(clk),
		.we(state_q == ST_READ),
		.waddr(pad_q),
		.wdata(cur_q),
		.re(accept),
		.raddr(PAD_AW'(in_ch.pad_index)),
		.rdata(ram_rdata)
	);

	gic_math u_math (
		.clk(clk),
		.arst_n(arst_n),
		.req(math_req_q),
		.rsp(math_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q <= LEFT_DZ_RESET;
			right_dz_q <= RIGHT_DZ_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_DZ: left_dz_q <= cfg_data;
				REG_RIGHT_DZ: right_dz_q <= cfg_data;
				default: left_dz_q <= left_dz_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			out_valid_q <= 1'b0;
			math_req_q <= '0;
		end else begin
			math_req_q.start <= 1'b0;
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= pad_ok ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					valid_q[pad_q] <= 1'b1;
					state_q <= ST_MULY;
				end
				ST_MULY: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (s_q > 32'(dz2_q)) begin
						math_req_q <= '{1'b1, OP_DIV, 64'(sqx_q), 64'(s_q), UNIT_DIV_STEPS};
						state_q <= ST_DIVX;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIVX: begin
					if (math_rsp.done) begin
						math_req_q <= '{1'b1, OP_SQRT, 64'(math_rsp.value), UNIT_SQRT_BIT,
							UNIT_SQRT_STEPS};
						state_q <= ST_SQX;
					end
				end
				ST_SQX: begin
					if (math_rsp.done) begin
						math_req_q <= '{1'b1, OP_DIV, 64'(sqy_q), 64'(s_q), UNIT_DIV_STEPS};
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (math_rsp.done) begin
						math_req_q <= '{1'b1, OP_SQRT, 64'(math_rsp.value), UNIT_SQRT_BIT,
							UNIT_SQRT_STEPS};
						state_q <= ST_SQY;
					end
				end
				ST_SQY: begin
					if (math_rsp.done) begin
						if ((s_q >= FULL_RANGE_SQ) || (left_dz_q == DZ_FULL)) begin
							state_q <= ST_DONE;
						end else begin
							math_req_q <= '{1'b1, OP_SQRT, {s_q, 32'b0}, SPEED_SQRT_BIT,
								SPEED_SQRT_STEPS};
							state_q <= ST_SPD;
						end
					end
				end
				ST_SPD: begin
					if (math_rsp.done) begin
						if (spd_num >= {1'b0, spd_den, 16'b0}) begin
							state_q <= ST_DONE;
						end else begin
							math_req_q <= '{1'b1, OP_DIV, 64'(spd_num),
								64'({spd_den, 15'b0}), SPEED_DIV_STEPS};
							state_q <= ST_SPDDIV;
						end
					end
				end
				ST_SPDDIV: begin
					if (math_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pad_q <= PAD_AW'(in_ch.pad_index);
					cur_q <= '{in_ch.buttons, in_ch.left_x, in_ch.left_y,
						in_ch.right_x, in_ch.right_y};
					pressed_q <= '0;
					released_q <= '0;
					dir_x_q <= '0;
					dir_y_q <= '0;
					speed_q <= '0;
					lchg_q <= 1'b0;
					rchg_q <= 1'b0;
				end
			end
			ST_READ: begin
				pressed_q <= cur_q.buttons & ~prev.buttons;
				released_q <= prev.buttons & ~cur_q.buttons;
				lchg_q <= stick_changed(cur_q.left_x, cur_q.left_y, prev.left_x,
					prev.left_y, left_dz_q);
				rchg_q <= stick_changed(cur_q.right_x, cur_q.right_y, prev.right_x,
					prev.right_y, right_dz_q);
				sqx_q <= ax * ax;
				dz2_q <= left_dz_q * left_dz_q;
			end
			ST_MULY: sqy_q <= ay * ay;
			ST_SUM: s_q <= sqx_q + sqy_q;
			ST_SQX: begin
				if (math_rsp.done) begin
					dir_x_q <= to_dir(math_rsp.value, cur_q.left_x[15]);
				end
			end
			ST_SQY: begin
				if (math_rsp.done) begin
					dir_y_q <= to_dir(math_rsp.value, cur_q.left_y[15]);
					speed_q <= SPEED_MAX;
				end
			end
			ST_SPD: begin
				if (math_rsp.done) begin
					speed_q <= SPEED_MAX;
				end
			end
			ST_SPDDIV: begin
				if (math_rsp.done) begin
					speed_q <= math_rsp.value[15:0];
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_pressed_q <= pressed_q;
					out_released_q <= released_q;
					out_dir_x_q <= dir_x_q;
					out_dir_y_q <= dir_y_q;
					out_speed_q <= speed_q;
					out_lchg_q <= lchg_q;
					out_rchg_q <= rchg_q;
				end
			end
			default: begin
				s_q <= s_q;
			end
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.pressed_edges = out_pressed_q;
	assign out_ch.released_edges = out_released_q;
	assign out_ch.direction_x = out_dir_x_q;
	assign out_ch.direction_y = out_dir_y_q;
	assign out_ch.speed = out_speed_q;
	assign out_ch.left_changed = out_lchg_q;
	assign out_ch.right_changed = out_rchg_q;

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("report accepted while another is in work");

	a_math_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		math_rsp.done |-> (state_q == ST_DIVX || state_q == ST_SQX || state_q == ST_DIVY
			|| state_q == ST_SQY || state_q == ST_SPD || state_q == ST_SPDDIV))
		else $error("arithmetic unit finished outside a wait state");

	a_speed_has_direction: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.speed != 16'd0) |->
			(out_ch.direction_x != 16'sd0 || out_ch.direction_y != 16'sd0))
		else $error("nonzero speed without a direction");
`endif
endmodule

FILE: design/gic_ram.sv
// Generic single-port-write, registered-read RAM.
module gic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: design/gic_math.sv
// Shared iterative unit: restoring division and digit-by-digit square root.
module gic_math (
	input logic clk,
	input logic arst_n,
	input gic_pkg::math_req_t req,
	output gic_pkg::math_rsp_t rsp
);
	import gic_pkg::*;

	logic busy_q;
	logic done_q;
	logic first_q;
	math_op_t op_q;
	logic [STEPS_W-1:0] cnt_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [63:0] q_q;

	logic [63:0] div_rs;
	logic div_ge;
	logic [63:0] sq_t;
	logic sq_ge;

	assign div_rs = first_q ? r_q : {r_q[62:0], 1'b0};
	assign div_ge = div_rs >= d_q;
	assign sq_t = q_q + d_q;
	assign sq_ge = r_q >= sq_t;

	assign rsp.done = done_q;
	assign rsp.value = q_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			first_q <= 1'b0;
			op_q <= OP_DIV;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				first_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= req.steps;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEPS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= req.a;
			d_q <= req.b;
			q_q <= '0;
		end else if (busy_q) begin
			case (op_q)
				OP_DIV: begin
					if (div_ge) begin
						r_q <= div_rs - d_q;
						q_q <= {q_q[62:0], 1'b1};
					end else begin
						r_q <= div_rs;
						q_q <= {q_q[62:0], 1'b0};
					end
				end
				OP_SQRT: begin
					if (sq_ge) begin
						r_q <= r_q - sq_t;
						q_q <= (q_q >> 1) + d_q;
					end else begin
						q_q <= q_q >> 1;
					end
					d_q <= d_q >> 2;
				end
				default: begin
					q_q <= q_q;
				end
			endcase
		end
	end
endmodule

FILE: sim/tb.sv
// Self-checking testbench of the gamepad input conditioner top level.
`timescale 1ns / 1ps

module tb;
	import gic_pkg::*;

	typedef struct {
		logic [1:0] pad;
		logic [15:0] buttons;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} report_t;

	typedef struct {
		logic [15:0] pressed;
		logic [15:0] released;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [15:0] speed;
		logic left_chg;
		logic right_chg;
	} cond_t;

	typedef enum logic {ROW_CFG, ROW_REPORT} row_kind_e;

	typedef struct {
		row_kind_e kind;
		report_t rep;
		bit typed;
		cond_t want;
		logic [DZ_W-1:0] lz;
		logic [DZ_W-1:0] rz;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_LEFT_DZ;
	logic [DZ_W-1:0] cfg_data = '0;

	gic_in_if in_ch ();
	gic_out_if out_ch ();

	gamepad_input_conditioner_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [DZ_W-1:0] left_dz = LEFT_DZ_RESET;
	logic [DZ_W-1:0] right_dz = RIGHT_DZ_RESET;
	prev_t last_report [4];
	cond_t pending_results [$];
	row_t dir_rows [$];
	int errors = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag(logic signed [15:0] v);
		int x;
		x = v;
		return x < 0 ? -x : x;
	endfunction

	function automatic bit in_box(logic signed [15:0] x, logic signed [15:0] y,
			longint unsigned dz);
		return mag(x) <= dz && mag(y) <= dz;
	endfunction

	function automatic bit moved(logic signed [15:0] cx, logic signed [15:0] cy,
			logic signed [15:0] px, logic signed [15:0] py, longint unsigned dz);
		bit ci;
		bit pi;
		ci = in_box(cx, cy, dz);
		pi = in_box(px, py, dz);
		return (ci != pi) || (!ci && (cx != px || cy != py));
	endfunction

	function automatic logic [15:0] unit_axis(logic signed [15:0] v, logic [63:0] s);
		logic [63:0] a;
		logic [63:0] q;
		a = mag(v);
		q = root64(((a * a) << 30) / s);
		if (q > 32767) q = 32767;
		if (v < 0) q = (64'h10000 - q) & 64'hFFFF;
		return q[15:0];
	endfunction

	function automatic cond_t condition_report(report_t r);
		cond_t c;
		prev_t p;
		logic [63:0] dz;
		logic [63:0] s;
		logic [63:0] m;
		logic [63:0] q;
		p = last_report[r.pad];
		dz = left_dz;
		s = mag(r.lx) * mag(r.lx) + mag(r.ly) * mag(r.ly);
		c.pressed = r.buttons & ~p.buttons;
		c.released = p.buttons & ~r.buttons;
		c.dir_x = '0;
		c.dir_y = '0;
		c.speed = '0;
		if (s > dz * dz) begin
			c.dir_x = unit_axis(r.lx, s);
			c.dir_y = unit_axis(r.ly, s);
			if (s >= 64'd1073676289 || dz >= 32767) begin
				c.speed = 16'hFFFF;
			end else begin
				m = root64(s << 32);
				q = (m - (dz << 16)) / (64'd32767 - dz);
				c.speed = q > 65535 ? 16'hFFFF : q[15:0];
			end
		end
		c.left_chg = moved(r.lx, r.ly, p.left_x, p.left_y, left_dz);
		c.right_chg = moved(r.rx, r.ry, p.right_x, p.right_y, right_dz);
		last_report[r.pad] = '{r.buttons, r.lx, r.ly, r.rx, r.ry};
		return c;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				cond_t w;
				w = pending_results.pop_front();
				if (out_ch.pressed_edges !== w.pressed)
					report_mismatch("pressed_edges", out_ch.pressed_edges, w.pressed);
				if (out_ch.released_edges !== w.released)
					report_mismatch("released_edges", out_ch.released_edges, w.released);
				if (out_ch.direction_x !== w.dir_x)
					report_mismatch("direction_x", out_ch.direction_x, w.dir_x);
				if (out_ch.direction_y !== w.dir_y)
					report_mismatch("direction_y", out_ch.direction_y, w.dir_y);
				if (out_ch.speed !== w.speed)
					report_mismatch("speed", out_ch.speed, w.speed);
				if (out_ch.left_changed !== w.left_chg)
					report_mismatch("left_changed", out_ch.left_changed, w.left_chg);
				if (out_ch.right_changed !== w.right_chg)
					report_mismatch("right_changed", out_ch.right_changed, w.right_chg);
			end
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= calm || ($urandom_range(99) >= 21);
			end
		end
	end

	task automatic wait_idle();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_dead_zones(logic [DZ_W-1:0] lz, logic [DZ_W-1:0] rz);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_LEFT_DZ;
		cfg_data <= lz;
		@(posedge clk);
		cfg_index <= REG_RIGHT_DZ;
		cfg_data <= rz;
		@(posedge clk);
		cfg_we <= 1'b0;
		left_dz = lz;
		right_dz = rz;
		@(posedge clk);
	endtask

	task automatic send_report(report_t r, bit typed, cond_t want);
		bit rdy;
		cond_t c;
		if (!calm && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pad_index <= r.pad;
		in_ch.buttons <= r.buttons;
		in_ch.left_x <= r.lx;
		in_ch.left_y <= r.ly;
		in_ch.right_x <= r.rx;
		in_ch.right_y <= r.ry;
		do begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end while (!rdy);
		c = condition_report(r);
		pending_results.push_back(typed ? want : c);
	endtask

	function automatic report_t mk(logic [1:0] pad, logic [15:0] btn, int lx, int ly,
			int rx, int ry);
		report_t r;
		r.pad = pad;
		r.buttons = btn;
		r.lx = lx;
		r.ly = ly;
		r.rx = rx;
		r.ry = ry;
		return r;
	endfunction

	task automatic add_report(report_t r);
		row_t row;
		row.kind = ROW_REPORT;
		row.rep = r;
		row.typed = 1'b0;
		dir_rows.push_back(row);
	endtask

	task automatic add_typed(report_t r, cond_t want);
		row_t row;
		row.kind = ROW_REPORT;
		row.rep = r;
		row.typed = 1'b1;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic add_cfg(logic [DZ_W-1:0] lz, logic [DZ_W-1:0] rz);
		row_t row;
		row.kind = ROW_CFG;
		row.lz = lz;
		row.rz = rz;
		dir_rows.push_back(row);
	endtask

	function automatic logic signed [15:0] clamp16(int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v;
	endfunction

	function automatic logic signed [15:0] pick_axis(int dz);
		int sel;
		int mags [6];
		mags = '{-32768, -32767, -1, 0, 1, 32767};
		sel = $urandom_range(5);
		case (sel)
			0, 1: begin
				return $urandom;
			end
			2: begin
				return mags[$urandom_range(5)];
			end
			3, 4: begin
				return clamp16(($urandom_range(1) ? 1 : -1) * (dz + $urandom_range(8) - 4));
			end
			default: begin
				return $signed(16'($urandom_range(2000))) - 16'sd1000;
			end
		endcase
	endfunction

	function automatic report_t random_report();
		report_t r;
		prev_t p;
		r.pad = $urandom_range(3);
		r.buttons = $urandom;
		if ($urandom_range(9) < 2) begin
			p = last_report[r.pad];
			r.lx = p.left_x;
			r.ly = p.left_y;
			r.rx = p.right_x;
			r.ry = p.right_y;
			if ($urandom_range(1)) r.buttons = p.buttons;
			if ($urandom_range(1)) r.ly = r.ly + 16'sd1;
		end else begin
			r.lx = pick_axis(left_dz);
			r.ly = pick_axis(left_dz);
			r.rx = pick_axis(right_dz);
			r.ry = pick_axis(right_dz);
		end
		return r;
	endfunction

	initial begin
		cond_t zero;
		cond_t w;
		logic [DZ_W-1:0] lz_set [6];
		logic [DZ_W-1:0] rz_set [6];
		zero = '{16'h0, 16'h0, 16'sh0, 16'sh0, 16'h0, 1'b0, 1'b0};
		for (int i = 0; i < 4; i++) last_report[i] = '0;
		in_ch.valid = 1'b0;
		in_ch.pad_index = '0;
		in_ch.buttons = '0;
		in_ch.left_x = '0;
		in_ch.left_y = '0;
		in_ch.right_x = '0;
		in_ch.right_y = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		add_typed(mk(0, 16'h0000, 0, 0, 0, 0), zero);
		w = '{16'hFFFF, 16'h0, 16'sh7FFF, 16'sh0, 16'hFFFF, 1'b1, 1'b0};
		add_typed(mk(1, 16'hFFFF, 32767, 0, 0, 0), w);
		w = '{16'h0, 16'hFFFF, 16'sh8001, 16'sh0, 16'hFFFF, 1'b1, 1'b0};
		add_typed(mk(1, 16'h0000, -32768, 0, 0, 0), w);
		add_typed(mk(2, 16'h0000, 7849, 0, 0, 0), zero);
		add_report(mk(2, 16'h8001, 7850, 0, 8689, -8689));
		add_report(mk(2, 16'h0001, 7850, 0, 8690, 0));
		add_report(mk(2, 16'h0001, 7850, 0, 8690, 0));
		add_report(mk(3, 16'h5555, -32768, -32768, -32768, -32768));
		add_report(mk(3, 16'hAAAA, 32767, 32767, 32767, 32767));
		add_report(mk(0, 16'h00FF, 5000, -6000, 100, 100));
		add_report(mk(0, 16'hFF00, -5550, 5551, -9000, 0));
		add_cfg(0, 0);
		add_report(mk(1, 16'h1234, 0, 0, 0, 0));
		add_report(mk(1, 16'h4321, 1, 0, 0, -1));
		add_report(mk(1, 16'h4321, -1, -1, 1, 1));
		add_cfg(DZ_FULL, DZ_FULL);
		add_report(mk(2, 16'hFFFF, 100, -100, 32767, 0));
		add_report(mk(2, 16'h0000, -32768, -32768, -32768, 5));
		add_report(mk(2, 16'h0000, 32767, 32767, 0, 0));
		add_cfg(15'd32766, 15'd1);
		add_report(mk(3, 16'h0F0F, 32766, 0, 1, 1));
		add_report(mk(3, 16'hF0F0, 32767, 1, 2, 0));
		add_report(mk(3, 16'h0000, -20000, 25000, -2, 2));
		add_cfg(LEFT_DZ_RESET, RIGHT_DZ_RESET);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				in_ch.valid <= 1'b0;
				write_dead_zones(dir_rows[i].lz, dir_rows[i].rz);
			end else begin
				send_report(dir_rows[i].rep, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		lz_set = '{LEFT_DZ_RESET, 15'd0, DZ_FULL, 15'd32766, 15'd0, 15'($urandom)};
		rz_set = '{RIGHT_DZ_RESET, 15'd0, DZ_FULL, 15'd0, 15'd32766, 15'($urandom)};
		for (int ph = 0; ph < 6; ph++) begin
			in_ch.valid <= 1'b0;
			write_dead_zones(lz_set[ph], rz_set[ph]);
			for (int n = 0; n < 250; n++) begin
				calm = (ph == 3 && n < 200);
				if (ph == 1 && n == 50) hold_req = 1'b1;
				send_report(random_report(), 1'b0, zero);
			end
		end
		calm = 1'b0;
		in_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: gamepad_input_conditioner_top.f
design/gic_pkg.sv
design/gic_in_if.sv
design/gic_out_if.sv
design/gic_ram.sv
design/gic_math.sv
design/gamepad_input_conditioner_top.sv
sim/tb.sv
